// ===== rtl/core/qru_pkg.sv =====
// Package with the types, codes and arithmetic helpers of the quaternion rotate unit.
package qru_pkg;

  typedef enum logic [1:0] {
    MODE_ROT = 2'd0,
    MODE_INV = 2'd1,
    MODE_MUL = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] opd_t;
  typedef logic signed [35:0] prod_t;
  typedef logic signed [37:0] acc_t;

  typedef struct packed {
    opd_t x;
    opd_t y;
    opd_t z;
    opd_t w;
  } quat_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } res_t;

  typedef struct packed {
    mode_e mode;
    logic  sat;
    res_t  a;
  } side_t;

  localparam int unsigned QShift = 30;
  localparam opd_t        QOne   = opd_t'(1) <<< QShift;
  localparam word_t       WordMax = {1'b0, {31{1'b1}}};
  localparam word_t       WordMin = {1'b1, {31{1'b0}}};

  function automatic opd_t ext_opd(word_t v);
    return {v[31], v};
  endfunction

  function automatic quat_t widen(res_t v);
    quat_t q;
    q.x = ext_opd(v.x);
    q.y = ext_opd(v.y);
    q.z = ext_opd(v.z);
    q.w = ext_opd(v.w);
    return q;
  endfunction

  // The negation is exact thanks to the extra operand bit.
  function automatic quat_t conj(res_t v);
    quat_t q;
    q   = widen(v);
    q.x = -q.x;
    q.y = -q.y;
    q.z = -q.z;
    return q;
  endfunction

  // Full product, then an arithmetic shift that rounds toward minus infinity.
  function automatic prod_t mul_tr(opd_t a, opd_t b);
    logic signed [65:0] m;
    m = 66'(a) * 66'(b);
    return m[65:30];
  endfunction

  function automatic acc_t ext_acc(prod_t v);
    return {{2{v[35]}}, v};
  endfunction

  function automatic logic ovf(acc_t v);
    return !((v[37:31] == '0) || (v[37:31] == '1));
  endfunction

  function automatic word_t clip(acc_t v);
    word_t r;
    if (!ovf(v)) begin
      r = v[31:0];
    end else if (v[37]) begin
      r = WordMin;
    end else begin
      r = WordMax;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/qru_qmul.sv =====
// Two-stage Hamilton product: registered products, then registered sums with saturation.
module qru_qmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qru_pkg::quat_t p_i,
  input  qru_pkg::quat_t q_i,
  input  qru_pkg::side_t side_i,
  output logic          valid_o,
  output qru_pkg::res_t  r_o,
  output qru_pkg::side_t side_o
);
  import qru_pkg::*;

  prod_t m_d [16];
  prod_t m_q [16];
  side_t side_a_q;
  logic  valid_a_q;
  acc_t  sx, sy, sz, sw;
  res_t  r_d;
  side_t side_d;
  logic  valid_b_q;
  res_t  r_q;
  side_t side_b_q;

  always_comb begin
    m_d[0]  = mul_tr(p_i.w, q_i.x);
    m_d[1]  = mul_tr(p_i.x, q_i.w);
    m_d[2]  = mul_tr(p_i.y, q_i.z);
    m_d[3]  = mul_tr(p_i.z, q_i.y);
    m_d[4]  = mul_tr(p_i.w, q_i.y);
    m_d[5]  = mul_tr(p_i.y, q_i.w);
    m_d[6]  = mul_tr(p_i.z, q_i.x);
    m_d[7]  = mul_tr(p_i.x, q_i.z);
    m_d[8]  = mul_tr(p_i.w, q_i.z);
    m_d[9]  = mul_tr(p_i.z, q_i.w);
    m_d[10] = mul_tr(p_i.x, q_i.y);
    m_d[11] = mul_tr(p_i.y, q_i.x);
    m_d[12] = mul_tr(p_i.w, q_i.w);
    m_d[13] = mul_tr(p_i.x, q_i.x);
    m_d[14] = mul_tr(p_i.y, q_i.y);
    m_d[15] = mul_tr(p_i.z, q_i.z);
  end

  always_comb begin
    sx = ext_acc(m_q[0]) + ext_acc(m_q[1]) + ext_acc(m_q[2]) - ext_acc(m_q[3]);
    sy = ext_acc(m_q[4]) + ext_acc(m_q[5]) + ext_acc(m_q[6]) - ext_acc(m_q[7]);
    sz = ext_acc(m_q[8]) + ext_acc(m_q[9]) + ext_acc(m_q[10]) - ext_acc(m_q[11]);
    sw = ext_acc(m_q[12]) - ext_acc(m_q[13]) - ext_acc(m_q[14]) - ext_acc(m_q[15]);
    r_d.x = clip(sx);
    r_d.y = clip(sy);
    r_d.z = clip(sz);
    r_d.w = clip(sw);
    side_d     = side_a_q;
    side_d.sat = side_a_q.sat | ovf(sx) | ovf(sy) | ovf(sz) | ovf(sw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= m_d;
      side_a_q <= side_i;
      r_q      <= r_d;
      side_b_q <= side_d;
    end
  end

  assign valid_o = valid_b_q;
  assign r_o     = r_q;
  assign side_o  = side_b_q;

endmodule

// ===== rtl/core/quaternion_rotate_unit.sv =====
// Top level of the quaternion rotate unit: operand selection, two product passes, output stage.
// Throughput is one transaction per cycle while the output is not stalled; two passes of the same product pipeline,
// each a multiply stage and a sum-and-saturate stage, feed the output register.
// The whole pipeline advances together whenever the output register is empty or being taken.
// Reset clears only the valid bits; the data registers are not reset.
module quaternion_rotate_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up.
  input  logic [255:0] s_axis_tdata_i,
  // mode.
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // r_x, r_y, r_z, r_w from the lowest bit up.
  output logic [127:0] m_axis_tdata_o,
  // saturated.
  output logic         m_axis_tuser_o
);
  import qru_pkg::*;

  logic  pipe_en;
  mode_e in_mode;
  res_t  in_a;
  res_t  in_b;
  quat_t p1, q1, p2, q2;
  side_t side1;
  logic  v1, v2;
  res_t  t1, r2;
  side_t s1, s2;
  res_t  out_d;
  logic  sat_d;
  logic  out_valid_q;
  res_t  out_q;
  logic  sat_q;
  mode_e out_mode_q;

  assign pipe_en         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  always_comb begin
    in_mode = mode_e'(s_axis_tuser_i);
    in_a.x  = s_axis_tdata_i[31:0];
    in_a.y  = s_axis_tdata_i[63:32];
    in_a.z  = s_axis_tdata_i[95:64];
    in_a.w  = s_axis_tdata_i[127:96];
    in_b.x  = s_axis_tdata_i[159:128];
    in_b.y  = s_axis_tdata_i[191:160];
    in_b.z  = s_axis_tdata_i[223:192];
    in_b.w  = s_axis_tdata_i[255:224];

    q1 = widen(in_b);
    if (in_mode == MODE_ROT || in_mode == MODE_INV) begin
      q1.w = '0;
    end
    p1 = (in_mode == MODE_INV) ? conj(in_a) : widen(in_a);

    side1.mode = in_mode;
    side1.sat  = 1'b0;
    side1.a    = in_a;
  end

  qru_qmul u_pass1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid_i && pipe_en),
    .p_i     (p1),
    .q_i     (q1),
    .side_i  (side1),
    .valid_o (v1),
    .r_o     (t1),
    .side_o  (s1)
  );

  // The product mode passes through the second pass as a multiply by the identity.
  always_comb begin
    p2 = widen(t1);
    case (s1.mode)
      MODE_ROT: q2 = conj(s1.a);
      MODE_INV: q2 = widen(s1.a);
      default: begin
        q2   = '0;
        q2.w = QOne;
      end
    endcase
  end

  qru_qmul u_pass2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v1),
    .p_i     (p2),
    .q_i     (q2),
    .side_i  (s1),
    .valid_o (v2),
    .r_o     (r2),
    .side_o  (s2)
  );

  always_comb begin
    out_d = r2;
    sat_d = s2.sat;
    case (s2.mode)
      MODE_ROT, MODE_INV: out_d.w = '0;
      MODE_MUL: out_d = r2;
      default: begin
        out_d = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q      <= out_d;
      sat_q      <= sat_d;
      out_mode_q <= s2.mode;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.w, out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser_o  = sat_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable({v1, v2, out_valid_q}))
    else $error("pipeline valid bits moved during a stall");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v2))
    else $error("output became valid without a transaction in the last pass");

  a_rotate_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_mode_q == MODE_ROT || out_mode_q == MODE_INV)
      |-> (m_axis_tdata_o[127:96] == '0))
    else $error("rotation result carries a nonzero scalar part");

endmodule

// ===== tb/tb_quaternion_rotate_unit.sv =====
// Self-checking testbench for the quaternion rotate unit: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_quaternion_rotate_unit;
  import qru_pkg::*;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned PhaseItems = 325;
  localparam int unsigned HoldCycles = 80;
  localparam word_t       SinCos45   = 32'sd759250125;
  localparam word_t       OneQ16     = 32'sd65536;

  typedef struct packed {
    mode_e mode;
    res_t  a;
    res_t  b;
  } job_t;

  typedef struct packed {
    res_t r;
    logic sat;
  } rot_out_t;

  typedef struct packed {
    job_t     job;
    logic     lit;
    rot_out_t want;
  } row_t;

  typedef longint quad_t[4];

  logic         clk_i;
  logic         rst_n;
  logic         s_valid;
  logic [255:0] s_data;
  logic [1:0]   s_user;
  logic         m_ready;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  rot_out_t     pending_rot[$];
  row_t         plan[$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;
  int unsigned  hold_left;
  bit           hold_req;

  quaternion_rotate_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint shr_mul(longint p, longint q);
    return (p * q) >>> 30;
  endfunction

  function automatic longint clamp32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void hamilton(input quad_t p, input quad_t q, output quad_t r,
                                   inout bit hit);
    r[0] = clamp32(shr_mul(p[3], q[0]) + shr_mul(p[0], q[3]) + shr_mul(p[1], q[2])
                   - shr_mul(p[2], q[1]), hit);
    r[1] = clamp32(shr_mul(p[3], q[1]) + shr_mul(p[1], q[3]) + shr_mul(p[2], q[0])
                   - shr_mul(p[0], q[2]), hit);
    r[2] = clamp32(shr_mul(p[3], q[2]) + shr_mul(p[2], q[3]) + shr_mul(p[0], q[1])
                   - shr_mul(p[1], q[0]), hit);
    r[3] = clamp32(shr_mul(p[3], q[3]) - shr_mul(p[0], q[0]) - shr_mul(p[1], q[1])
                   - shr_mul(p[2], q[2]), hit);
  endfunction

  function automatic rot_out_t predict_rotation(job_t j);
    quad_t    qa;
    quad_t    qc;
    quad_t    qb;
    quad_t    qt;
    quad_t    qr;
    bit       hit;
    rot_out_t o;
    hit = 1'b0;
    qa  = '{longint'(j.a.x), longint'(j.a.y), longint'(j.a.z), longint'(j.a.w)};
    qc  = '{-qa[0], -qa[1], -qa[2], qa[3]};
    qb  = '{longint'(j.b.x), longint'(j.b.y), longint'(j.b.z), longint'(j.b.w)};
    qr  = '{0, 0, 0, 0};
    case (j.mode)
      MODE_ROT: begin
        qb[3] = 0;
        hamilton(qa, qb, qt, hit);
        hamilton(qt, qc, qr, hit);
        qr[3] = 0;
      end
      MODE_INV: begin
        qb[3] = 0;
        hamilton(qc, qb, qt, hit);
        hamilton(qt, qa, qr, hit);
        qr[3] = 0;
      end
      MODE_MUL: begin
        hamilton(qa, qb, qr, hit);
      end
      default: begin
      end
    endcase
    o.r.x = word_t'(qr[0]);
    o.r.y = word_t'(qr[1]);
    o.r.z = word_t'(qr[2]);
    o.r.w = word_t'(qr[3]);
    o.sat = hit;
    return o;
  endfunction

  function automatic res_t quat(word_t x, word_t y, word_t z, word_t w);
    res_t q;
    q.x = x;
    q.y = y;
    q.z = z;
    q.w = w;
    return q;
  endfunction

  function automatic void add_row(mode_e m, res_t a, res_t b, bit lit, res_t r, bit sat);
    row_t row;
    row.job.mode = m;
    row.job.a    = a;
    row.job.b    = b;
    row.lit      = lit;
    row.want.r   = r;
    row.want.sat = sat;
    plan.push_back(row);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0, 1: return word_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return WordMax;
          1: return WordMin;
          2: return '0;
          3: return '1;
          default: return word_t'(QOne);
        endcase
      end
      default: return word_t'($signed($urandom) >>> $urandom_range(1, 24));
    endcase
  endfunction

  function automatic job_t rand_job();
    job_t j;
    case ($urandom_range(9))
      0, 1, 2: j.mode = MODE_ROT;
      3, 4, 5: j.mode = MODE_INV;
      6, 7, 8: j.mode = MODE_MUL;
      default: j.mode = MODE_RSV;
    endcase
    j.a = quat(rand_word(), rand_word(), rand_word(), rand_word());
    j.b = quat(rand_word(), rand_word(), rand_word(), rand_word());
    return j;
  endfunction

  function automatic void check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                 $realtime, name, want, want, got, got);
      end
    end
  endfunction

  task automatic send_job(job_t j, rot_out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {j.b.w, j.b.z, j.b.y, j.b.x, j.a.w, j.a.z, j.a.y, j.a.x};
    s_user  <= j.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_rot.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_ready  <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    rot_out_t want;
    rot_out_t got;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got.r.x = m_axis_tdata_o[31:0];
      got.r.y = m_axis_tdata_o[63:32];
      got.r.z = m_axis_tdata_o[95:64];
      got.r.w = m_axis_tdata_o[127:96];
      got.sat = m_axis_tuser_o;
      if (pending_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result transaction with nothing expected", $realtime);
        end
      end else begin
        want = pending_rot.pop_front();
        check_field("r_x", want.r.x, got.r.x);
        check_field("r_y", want.r.y, got.r.y);
        check_field("r_z", want.r.z, got.r.z);
        check_field("r_w", want.r.w, got.r.w);
        check_field("saturated", word_t'(want.sat), word_t'(got.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    res_t zero_q;
    res_t ident;
    res_t vec;
    clk_i          = 1'b0;
    rst_n          = 1'b0;
    s_valid        = 1'b0;
    s_data         = '0;
    s_user         = MODE_ROT;
    m_ready        = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    zero_q         = quat('0, '0, '0, '0);
    ident          = quat('0, '0, '0, word_t'(QOne));
    vec            = quat(OneQ16, 2 * OneQ16, -3 * OneQ16, '0);

    // Identity, reserved-mode, zero-rotation and scalar-overflow rows carry hand-written results.
    add_row(MODE_ROT, ident, vec, 1'b1, vec, 1'b0);
    add_row(MODE_INV, ident, vec, 1'b1, vec, 1'b0);
    add_row(MODE_MUL, ident, quat(32'sh12345678, '1, WordMin, WordMax), 1'b1,
            quat(32'sh12345678, '1, WordMin, WordMax), 1'b0);
    add_row(MODE_RSV, quat(WordMax, WordMin, '1, 32'sd5), vec, 1'b1, zero_q, 1'b0);
    add_row(MODE_RSV, quat(WordMin, WordMin, WordMin, WordMin),
            quat(WordMin, WordMin, WordMin, WordMin), 1'b1, zero_q, 1'b0);
    add_row(MODE_ROT, zero_q, quat(WordMax, WordMin, WordMax, WordMin), 1'b1, zero_q, 1'b0);
    add_row(MODE_MUL, quat('0, '0, '0, WordMin), quat('0, '0, '0, WordMin), 1'b1,
            quat('0, '0, '0, WordMax), 1'b1);
    add_row(MODE_MUL, quat(WordMax, WordMax, WordMax, WordMax),
            quat(WordMax, WordMax, WordMax, WordMax), 1'b0, zero_q, 1'b0);
    add_row(MODE_MUL, quat(WordMin, WordMin, WordMin, WordMin),
            quat(WordMin, WordMin, WordMin, WordMin), 1'b0, zero_q, 1'b0);
    add_row(MODE_MUL, quat(WordMax, WordMin, WordMax, WordMin), quat('1, '1, '1, '1),
            1'b0, zero_q, 1'b0);
    add_row(MODE_ROT, quat(WordMin, '0, '0, '0), vec, 1'b0, zero_q, 1'b0);
    add_row(MODE_INV, quat('0, WordMin, WordMin, '0), vec, 1'b0, zero_q, 1'b0);
    add_row(MODE_INV, quat(WordMin, WordMin, WordMin, WordMin),
            quat(WordMax, WordMax, WordMax, '0), 1'b0, zero_q, 1'b0);
    add_row(MODE_ROT, quat('0, '0, '0, WordMax), quat(WordMax, WordMin, OneQ16, '0),
            1'b0, zero_q, 1'b0);
    add_row(MODE_ROT, quat('0, '0, SinCos45, SinCos45), quat(OneQ16, '0, '0, '0),
            1'b0, zero_q, 1'b0);
    add_row(MODE_INV, quat('0, '0, SinCos45, SinCos45), quat(OneQ16, '0, '0, '0),
            1'b0, zero_q, 1'b0);
    add_row(MODE_ROT, quat('1, '1, '1, '1), quat('1, '1, '1, '1), 1'b0, zero_q, 1'b0);
    add_row(MODE_ROT, quat(word_t'(QOne), '0, '0, '0), quat(OneQ16, OneQ16, OneQ16, '0),
            1'b0, zero_q, 1'b0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      send_job(plan[i].job, plan[i].lit ? plan[i].want : predict_rotation(plan[i].job));
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      job_t j;
      case (p)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          src_idle_pct   = 49;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 49;
        end
        default: begin
          src_idle_pct   = 34;
          sink_stall_pct = 34;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        j = rand_job();
        send_job(j, predict_rotation(j));
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_rot.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
